// File: rtl/max_pool_2d_argmax_unit_assert.svh
// Assertion macros for the max pooling block and its port checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef MAX_POOL_2D_ARGMAX_UNIT_ASSERT_SVH
`define MAX_POOL_2D_ARGMAX_UNIT_ASSERT_SVH

// Checked only outside reset.
`define MP2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define MP2A_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mp2a_pkg.sv
// Shared types and constants for the max pooling with argmax block.
// No dependencies.
`timescale 1ns / 1ps

package mp2a_pkg;

  localparam int DATA_W    = 16;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int WIN_W     = 3;
  localparam int GEOM_W    = 9;
  localparam int PH_W      = 2;

  localparam logic [WIN_W-1:0]  STEP_MAX        = 3'd4;
  localparam logic [WIN_W-1:0]  WINDOW_SIZE_RST = 3'd2;
  localparam logic [WIN_W-1:0]  STEP_RST        = 3'd2;
  localparam logic [GEOM_W-1:0] ROWS_RST        = 9'd32;
  localparam logic [GEOM_W-1:0] COLS_RST        = 9'd32;
  localparam logic [GEOM_W-1:0] PLANE_COUNT_RST = 9'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 3'd0,
    REG_STEP        = 3'd1,
    REG_ROWS        = 3'd2,
    REG_COLS        = 3'd3,
    REG_PLANE_COUNT = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Qualifies one line store read on its way to the compare unit.
  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

// File: rtl/mp2a_line_store.sv
// Line store: the last MAX_POOL rows of the current plane, one 16-bit sample per entry.
// Uses mp2a_pkg. One write port, one registered read port.
`timescale 1ns / 1ps

module mp2a_line_store
  import mp2a_pkg::*;
#(
  parameter int MAX_POOL  = 4,
  parameter int MAX_WIDTH = 256,
  localparam int SW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [SW-1:0]     wr_slot,
  input  logic [CW-1:0]     wr_col,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              re,
  input  logic [SW-1:0]     rd_slot,
  input  logic [CW-1:0]     rd_col,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [MAX_POOL][MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_slot][wr_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_slot][rd_col];
    end
  end

endmodule

// File: rtl/mp2a_argmax_unit.sv
// Shared compare unit: running maximum and its flat index over one window scan.
// Uses mp2a_pkg for widths and the scan control struct.
`timescale 1ns / 1ps

module mp2a_argmax_unit
  import mp2a_pkg::*;
(
  input  logic                     clk,
  input  scan_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] value,
  input  logic [IDX_W-1:0]         index,
  output logic signed [DATA_W-1:0] best_value,
  output logic [IDX_W-1:0]         best_index
);

  // Strict greater-than keeps the first maximum; the first entry always seeds.
  always_ff @(posedge clk) begin
    if (ctl.valid && (ctl.first || value > best_value)) begin
      best_value <= value;
      best_index <= index;
    end
  end

endmodule

// File: rtl/max_pool_2d_argmax_unit.sv
// Streaming 2-D max pooling with argmax over an NCHW tensor, samples in raster order
// (column, row, plane). A sample that does not close a window is taken while idle and the
// block stays ready for the next one. A sample that closes a k x k window is accepted, then
// the read addresses are set up, all k*k entries are read from the line store, a drain
// step follows, and the result is shown until out_ready takes it; no new sample is taken
// meanwhile. The single read port of the line store and the single comparator mean that
// one window entry is read and compared per cycle. The line store needs no clearing after
// reset. A write to any of the five listed registers restarts the tensor at index zero.
// Uses mp2a_pkg, mp2a_line_store and mp2a_argmax_unit.
`timescale 1ns / 1ps

module max_pool_2d_argmax_unit
  import mp2a_pkg::*;
#(
  parameter int MAX_POOL   = 4,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_PLANES = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] max_value,
  output logic [IDX_W-1:0]         winner_index,
  output logic [IDX_W-1:0]         output_position,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int KW  = $clog2(MAX_POOL + 1);
  localparam int SW  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PNW = $clog2(MAX_PLANES + 1);

  // configuration
  logic [WIN_W-1:0]  window_size;
  logic [WIN_W-1:0]  step;
  logic [GEOM_W-1:0] rows;
  logic [GEOM_W-1:0] cols;
  logic [GEOM_W-1:0] plane_count;
  logic              restart;

  logic [KW-1:0]    k_eff;
  logic [KW-1:0]    km1;
  logic [WIN_W-1:0] s_eff;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [PNW-1:0]   p_eff;

  // position of the next sample
  logic [CW-1:0]    col_cnt;
  logic [RW-1:0]    row_cnt;
  logic [PW-1:0]    plane_cnt;
  logic [SW-1:0]    slot;
  logic [PH_W-1:0]  col_ph;
  logic [PH_W-1:0]  row_ph;
  logic [IDX_W-1:0] idx_cnt;
  logic [IDX_W-1:0] out_cnt;

  logic in_fire;
  logic col_last, row_last, plane_last, tensor_end;
  logic col_reach, row_reach, hit;

  // window scan
  state_t           state, state_next;
  logic [SW-1:0]    win_slot;
  logic [CW-1:0]    win_col;
  logic [IDX_W-1:0] win_idx;
  logic [IDX_W-1:0] position;
  logic [SW-1:0]    rd_slot;
  logic [CW-1:0]    rd_col;
  logic [CW-1:0]    col_base;
  logic [KW-1:0]    m_cnt;
  logic [KW-1:0]    n_cnt;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] elem_idx;
  logic             rd_en;
  logic             scan_last;
  logic [SW:0]      slot_sum;
  logic [SW-1:0]    slot_start;
  logic [KW+WW-1:0] row_span;

  scan_ctl_t         issue;
  logic [IDX_W-1:0]  issue_idx;
  logic [DATA_W-1:0] rd_data;

  // Effective geometry: zero acts as one, large values saturate.
  always_comb begin
    if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (32'(window_size) > MAX_POOL) begin
      k_eff = KW'(MAX_POOL);
    end else begin
      k_eff = KW'(window_size);
    end
    if (step == '0) begin
      s_eff = WIN_W'(1);
    end else if (step > STEP_MAX) begin
      s_eff = STEP_MAX;
    end else begin
      s_eff = step;
    end
    if (cols == '0) begin
      w_eff = WW'(1);
    end else if (32'(cols) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cols);
    end
    if (rows == '0) begin
      h_eff = HW'(1);
    end else if (32'(rows) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(rows);
    end
    if (plane_count == '0) begin
      p_eff = PNW'(1);
    end else if (32'(plane_count) > MAX_PLANES) begin
      p_eff = PNW'(MAX_PLANES);
    end else begin
      p_eff = PNW'(plane_count);
    end
  end

  assign km1 = k_eff - KW'(1);

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_WINDOW_SIZE, REG_STEP, REG_ROWS, REG_COLS, REG_PLANE_COUNT: restart = cfg_we;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
      step        <= STEP_RST;
      rows        <= ROWS_RST;
      cols        <= COLS_RST;
      plane_count <= PLANE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_SIZE: window_size <= cfg_data[WIN_W-1:0];
        REG_STEP:        step        <= cfg_data[WIN_W-1:0];
        REG_ROWS:        rows        <= cfg_data;
        REG_COLS:        cols        <= cfg_data;
        REG_PLANE_COUNT: plane_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_fire    = in_valid && in_ready;
  assign col_last   = (32'(col_cnt) + 32'd1) == 32'(w_eff);
  assign row_last   = (32'(row_cnt) + 32'd1) == 32'(h_eff);
  assign plane_last = (32'(plane_cnt) + 32'd1) == 32'(p_eff);
  assign tensor_end = col_last && row_last && plane_last;
  assign col_reach  = (32'(col_cnt) + 32'd1) >= 32'(k_eff);
  assign row_reach  = (32'(row_cnt) + 32'd1) >= 32'(k_eff);
  // Phase counters track (pos + 1 - k) mod step once the window fits.
  assign hit = col_reach && row_reach && (col_ph == '0) && (row_ph == '0);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      plane_cnt <= '0;
      slot      <= '0;
      col_ph    <= '0;
      row_ph    <= '0;
      idx_cnt   <= '0;
      out_cnt   <= '0;
    end else if (in_fire) begin
      idx_cnt <= tensor_end ? '0 : idx_cnt + IDX_W'(1);
      if (tensor_end) begin
        out_cnt <= '0;
      end else if (hit) begin
        out_cnt <= out_cnt + IDX_W'(1);
      end
      if (col_last) begin
        col_cnt <= '0;
        col_ph  <= '0;
        if (row_last) begin
          row_cnt <= '0;
          row_ph  <= '0;
          slot    <= '0;
          plane_cnt <= plane_last ? '0 : plane_cnt + PW'(1);
        end else begin
          row_cnt <= row_cnt + RW'(1);
          slot    <= (32'(slot) == MAX_POOL - 1) ? '0 : slot + SW'(1);
          if (row_reach) begin
            row_ph <= ({1'b0, row_ph} == s_eff - WIN_W'(1)) ? '0 : row_ph + PH_W'(1);
          end else begin
            row_ph <= '0;
          end
        end
      end else begin
        col_cnt <= col_cnt + CW'(1);
        if (col_reach) begin
          col_ph <= ({1'b0, col_ph} == s_eff - WIN_W'(1)) ? '0 : col_ph + PH_W'(1);
        end else begin
          col_ph <= '0;
        end
      end
    end
  end

  // sequencer
  assign scan_last = (m_cnt == km1) && (n_cnt == km1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    rd_en      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && hit) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_SCAN;
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Line store slot of the window's top row, modulo MAX_POOL.
  always_comb begin
    slot_sum = (SW+1)'(win_slot) + (SW+1)'(MAX_POOL) - (SW+1)'(km1);
    if (32'(slot_sum) >= MAX_POOL) begin
      slot_sum = slot_sum - (SW+1)'(MAX_POOL);
    end
    slot_start = slot_sum[SW-1:0];
  end

  assign row_span = {{WW{1'b0}}, km1} * {{KW{1'b0}}, w_eff};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_slot <= slot;
      win_col  <= col_cnt;
      win_idx  <= idx_cnt;
      position <= out_cnt;
    end
    case (state)
      ST_SETUP: begin
        rd_slot  <= slot_start;
        rd_col   <= win_col - CW'(km1);
        col_base <= win_col - CW'(km1);
        m_cnt    <= '0;
        n_cnt    <= '0;
        row_idx  <= win_idx - IDX_W'(row_span) - IDX_W'(km1);
        elem_idx <= win_idx - IDX_W'(row_span) - IDX_W'(km1);
      end
      ST_SCAN: begin
        issue_idx <= elem_idx;
        if (n_cnt == km1) begin
          n_cnt    <= '0;
          m_cnt    <= m_cnt + KW'(1);
          rd_col   <= col_base;
          rd_slot  <= (32'(rd_slot) == MAX_POOL - 1) ? '0 : rd_slot + SW'(1);
          row_idx  <= row_idx + IDX_W'(w_eff);
          elem_idx <= row_idx + IDX_W'(w_eff);
        end else begin
          n_cnt    <= n_cnt + KW'(1);
          rd_col   <= rd_col + CW'(1);
          elem_idx <= elem_idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue.valid <= 1'b0;
      issue.first <= 1'b0;
    end else begin
      issue.valid <= rd_en;
      issue.first <= rd_en && (m_cnt == '0) && (n_cnt == '0);
    end
  end

  mp2a_line_store #(
    .MAX_POOL  (MAX_POOL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (in_fire),
    .wr_slot (slot),
    .wr_col  (col_cnt),
    .wr_data (sample),
    .re      (rd_en),
    .rd_slot (rd_slot),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  mp2a_argmax_unit u_argmax (
    .clk        (clk),
    .ctl        (issue),
    .value      (rd_data),
    .index      (issue_idx),
    .best_value (max_value),
    .best_index (winner_index)
  );

  assign output_position = position;

endmodule

// File: rtl/mp2a_checker.sv
// Port-level checker for max_pool_2d_argmax_unit, bound to the top level below.
// Uses mp2a_pkg and the assertion macros in max_pool_2d_argmax_unit_assert.svh.
`timescale 1ns / 1ps
`include "max_pool_2d_argmax_unit_assert.svh"

module mp2a_checker
  import mp2a_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] max_value,
  input logic [IDX_W-1:0]         winner_index,
  input logic [IDX_W-1:0]         output_position
);

  // a stalled result keeps its fields
  `MP2A_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(max_value) && $stable(winner_index) && $stable(output_position), "result changed while stalled")
  // one item in flight: no new item while a result waits
  `MP2A_ASSERT(a_one_item, out_valid |-> !in_ready, "input taken while a result is pending")
  // a window scan comes first: no result straight after an accepted item
  `MP2A_ASSERT(a_no_instant, in_valid && in_ready |=> !out_valid, "result one cycle after an item")
  `MP2A_ASSERT_ALWAYS(a_reset_idle, rst |=> in_ready && !out_valid, "not idle after reset")

endmodule

bind max_pool_2d_argmax_unit mp2a_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .max_value       (max_value),
  .winner_index    (winner_index),
  .output_position (output_position)
);

// File: verif/max_pool_2d_argmax_unit_test.sv
// Self-checking bench for max_pool_2d_argmax_unit: a directed table, then randomised
// register settings and sample streams, each result scored against an in-bench predictor.
// Needs mp2a_pkg and the block's RTL only.
`timescale 1ns / 1ps

module max_pool_2d_argmax_unit_test
  import mp2a_pkg::*;
();

  localparam int POOL_LIMIT   = 4;
  localparam int WIDTH_LIMIT  = 256;
  localparam int HEIGHT_LIMIT = 256;
  localparam int PLANE_LIMIT  = 256;
  localparam int LINE_DEPTH   = POOL_LIMIT * WIDTH_LIMIT;
  localparam int MAX_GAP      = 11;
  localparam int SETTLE       = 24;    // settle time after the last result, covers a 4x4 scan with margin
  localparam int HOLD_OFF     = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int ITEM_TARGET  = 1650;
  localparam int PHASE_CAP    = 200;

  // indexes past the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         winner;
    logic [IDX_W-1:0]         position;
  } pool_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_FEED, ROW_FEED_KNOWN} plan_kind_t;

  typedef struct packed {
    plan_kind_t               kind;
    logic [CFG_IDX_W-1:0]     index;
    logic [CFG_W-1:0]         data;
    logic signed [DATA_W-1:0] smp;
    pool_result_t             known;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] sample;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] max_value;
  logic [IDX_W-1:0]         winner_index;
  logic [IDX_W-1:0]         output_position;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // predictor copy of the block's registers and position
  logic [DATA_W-1:0] line_buf [LINE_DEPTH];
  int unsigned       col_pos, row_pos, plane_pos, result_pos;
  logic [WIN_W-1:0]  win_reg, step_reg;
  logic [GEOM_W-1:0] rows_reg, cols_reg, planes_reg;

  pool_result_t pending_results[$];
  plan_row_t    plan[$];
  int           errors, items_fed, results_seen, writes_made, stall_cycles;
  bit           tx_idle, rx_idle, hold_req;

  max_pool_2d_argmax_unit #(
    .MAX_POOL  (POOL_LIMIT),
    .MAX_WIDTH (WIDTH_LIMIT),
    .MAX_HEIGHT(HEIGHT_LIMIT),
    .MAX_PLANES(PLANE_LIMIT)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .max_value      (max_value),
    .winner_index   (winner_index),
    .output_position(output_position),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_tensor();
    col_pos    = 0;
    row_pos    = 0;
    plane_pos  = 0;
    result_pos = 0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
    bit listed;
    listed = 1'b1;
    case (idx)
      REG_WINDOW_SIZE: win_reg    = data[WIN_W-1:0];
      REG_STEP:        step_reg   = data[WIN_W-1:0];
      REG_ROWS:        rows_reg   = data[GEOM_W-1:0];
      REG_COLS:        cols_reg   = data[GEOM_W-1:0];
      REG_PLANE_COUNT: planes_reg = data[GEOM_W-1:0];
      default:         listed     = 1'b0;
    endcase
    if (listed) restart_tensor();
  endfunction

  // Stores the sample in the line buffer and, when it closes a window on the step
  // grid, works out the window maximum and where it sits in the tensor.
  function automatic bit pool_predict(input logic signed [DATA_W-1:0] s,
                                      output pool_result_t res);
    int unsigned              k, st, h, w, p, r, c, r0, c0, base, m, n, rr, cc, win_at;
    logic signed [DATA_W-1:0] v, best;
    bit                       seeded, hit;
    k  = clamp_cfg(win_reg, POOL_LIMIT);
    st = clamp_cfg(step_reg, STEP_MAX);
    h  = clamp_cfg(rows_reg, HEIGHT_LIMIT);
    w  = clamp_cfg(cols_reg, WIDTH_LIMIT);
    p  = clamp_cfg(planes_reg, PLANE_LIMIT);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    if (plane_pos >= p) plane_pos = 0;
    r = row_pos;
    c = col_pos;
    line_buf[(r % POOL_LIMIT) * WIDTH_LIMIT + c] = s;
    hit    = 1'b0;
    res    = '0;
    best   = '0;
    win_at = 0;
    if (r + 1 >= k && c + 1 >= k && (r + 1 - k) % st == 0 && (c + 1 - k) % st == 0) begin
      r0     = r + 1 - k;
      c0     = c + 1 - k;
      base   = plane_pos * h * w;
      seeded = 1'b0;
      for (m = 0; m < k; m++) begin
        for (n = 0; n < k; n++) begin
          rr = r0 + m;
          cc = c0 + n;
          v  = line_buf[(rr % POOL_LIMIT) * WIDTH_LIMIT + cc];
          // first entry always seeds; later ones must be strictly greater
          if (!seeded || v > best) begin
            best   = v;
            win_at = base + rr * w + cc;
            seeded = 1'b1;
          end
        end
      end
      res.value    = best;
      res.winner   = IDX_W'(win_at);
      res.position = IDX_W'(result_pos);
      result_pos   = (result_pos + 1) & ((1 << IDX_W) - 1);
      hit          = 1'b1;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        plane_pos++;
        if (plane_pos >= p) begin
          plane_pos  = 0;
          result_pos = 0;
        end
      end
    end
    return hit;
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = data;
    plan.push_back(row);
  endfunction

  function automatic void plan_feed(input logic [DATA_W-1:0] s);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_FEED;
    row.smp  = s;
    plan.push_back(row);
  endfunction

  function automatic void plan_known(input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] v,
                                     input logic [IDX_W-1:0] win, input logic [IDX_W-1:0] pos);
    plan_row_t row;
    row                = '0;
    row.kind           = ROW_FEED_KNOWN;
    row.smp            = s;
    row.known.value    = v;
    row.known.winner   = win;
    row.known.position = pos;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    errors++;
    $display("%0t: %s: got %0h, want %0h (result %0d)", $time, what, got, want,
             results_seen);
  endtask

  // Entered at a falling edge; leaves in_valid low until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_write(idx, data);
    writes_made++;
  endtask

  task automatic program_regs(input int k, input int s, input int h, input int w,
                              input int p);
    write_reg(REG_WINDOW_SIZE, CFG_W'(k));
    write_reg(REG_STEP, CFG_W'(s));
    write_reg(REG_ROWS, CFG_W'(h));
    write_reg(REG_COLS, CFG_W'(w));
    write_reg(REG_PLANE_COUNT, CFG_W'(p));
  endtask

  task automatic feed_item(input logic signed [DATA_W-1:0] s, input bit use_known,
                           input pool_result_t known);
    int           gap;
    bit           hit;
    pool_result_t res;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    hit = pool_predict(s, res);
    if (use_known) pending_results.push_back(known);
    else if (hit) pending_results.push_back(res);
    items_fed++;
    @(negedge clk);
  endtask

  // output side: random stalls, one long hold-off on request, scoring
  initial begin
    int           gap;
    pool_result_t want;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, max_value", IDX_W'(max_value), '0);
      end else begin
        want = pending_results.pop_front();
        if (max_value !== want.value)
          report_mismatch("max_value", IDX_W'(max_value), IDX_W'(want.value));
        if (winner_index !== want.winner)
          report_mismatch("winner_index", winner_index, want.winner);
        if (output_position !== want.position)
          report_mismatch("output_position", output_position, want.position);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int k, s, h, w, p, n, cut, i;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_WINDOW_SIZE;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_req  = 1'b0;
    win_reg    = WINDOW_SIZE_RST;
    step_reg   = STEP_RST;
    rows_reg   = ROWS_RST;
    cols_reg   = COLS_RST;
    planes_reg = PLANE_COUNT_RST;
    restart_tensor();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // two 2x2 planes, one window each
    plan_write(REG_WINDOW_SIZE, 9'd2);
    plan_write(REG_STEP, 9'd2);
    plan_write(REG_ROWS, 9'd2);
    plan_write(REG_COLS, 9'd2);
    plan_write(REG_PLANE_COUNT, 9'd2);
    // window all at the lowest value: first entry still wins
    plan_feed(16'h8000);
    plan_feed(16'h8000);
    plan_feed(16'h8000);
    plan_known(16'h8000, 16'h8000, 24'd0, 24'd0);
    // tie at the top keeps the earlier entry
    plan_feed(16'h7FFF);
    plan_feed(16'h7FFF);
    plan_feed(16'h8000);
    plan_known(16'h7FFF, 16'h7FFF, 24'd4, 24'd1);
    // tensor has wrapped: plane 0, output position 0
    plan_feed(16'h0001);
    plan_feed(16'h0000);
    plan_feed(16'hFFFF);
    plan_known(16'h0002, 16'h0002, 24'd3, 24'd0);
    // a write past the register list must not restart the tensor
    plan_feed(16'h0100);
    plan_feed(16'h0200);
    plan_write(REG_SPARE_FIRST, 9'h1FF);
    plan_feed(16'h0050);
    plan_known(16'h0300, 16'h0300, 24'd7, 24'd1);
    // zero everywhere acts as one: every item is a whole tensor
    plan_write(REG_WINDOW_SIZE, 9'd0);
    plan_write(REG_STEP, 9'd0);
    plan_write(REG_ROWS, 9'd0);
    plan_write(REG_COLS, 9'd0);
    plan_write(REG_PLANE_COUNT, 9'd0);
    plan_known(16'h8000, 16'h8000, 24'd0, 24'd0);
    plan_known(16'h7FFF, 16'h7FFF, 24'd0, 24'd0);
    // oversized window and step on a 3x3 plane: silent
    plan_write(REG_WINDOW_SIZE, 9'd7);
    plan_write(REG_STEP, 9'd7);
    plan_write(REG_ROWS, 9'd3);
    plan_write(REG_COLS, 9'd3);
    plan_write(REG_PLANE_COUNT, 9'd1);
    plan_feed(16'h1234);
    plan_feed(16'hEDCB);
    plan_feed(16'h5A5A);

    foreach (plan[j]) begin
      case (plan[j].kind)
        ROW_WRITE: write_reg(plan[j].index, plan[j].data);
        ROW_FEED:  feed_item(plan[j].smp, 1'b0, '0);
        default:   feed_item(plan[j].smp, 1'b1, plan[j].known);
      endcase
    end

    // every item closes a window; output held off while input is offered without gaps
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    program_regs(1, 1, 6, 6, 1);
    hold_req = 1'b1;
    repeat (36) feed_item(DATA_W'($urandom), 1'b0, '0);

    // geometry at and above the limits
    tx_idle = 1'b1;
    program_regs(1, $urandom_range(1, 4), 1, 9'h1FF, 1);
    repeat (WIDTH_LIMIT) feed_item(DATA_W'($urandom), 1'b0, '0);
    program_regs(1, $urandom_range(1, 4), HEIGHT_LIMIT, 1, 1);
    repeat (HEIGHT_LIMIT) feed_item(DATA_W'($urandom), 1'b0, '0);
    program_regs(1, 1, 1, 1, 9'h1FF);
    repeat (PLANE_LIMIT + 4) feed_item(DATA_W'($urandom), 1'b0, '0);

    // small random tensors, mostly whole, some cut short by the next setting
    while (items_fed < ITEM_TARGET) begin
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
      p = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      program_regs(k, s, h, w, p);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      n = clamp_cfg(h, HEIGHT_LIMIT) * clamp_cfg(w, WIDTH_LIMIT) * clamp_cfg(p, PLANE_LIMIT);
      n = n + $urandom_range(0, n / 2);
      if (n > PHASE_CAP) n = PHASE_CAP;
      cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
      for (i = 0; i < n; i++) begin
        // mid-tensor pause until the output side has caught up
        if (i == cut) begin
          if ($urandom_range(0, 1) != 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      CFG_W'($urandom));
          else
            drain_results();
        end
        feed_item(DATA_W'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    $display("Fed %0d samples, checked %0d pooled results, %0d register writes.",
             items_fed, results_seen, writes_made);
    $display("Covered clamped settings, full-width/height and 256-plane tensors, %0d-cycle stall.",
             HOLD_OFF);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
